[rtl/vmpc_pkg.sv]
// vmpc_pkg: shared types, codes and constants of the vmpc mac engine
// no dependencies; imported by vmpc_ctrl, vmpc_datapath and vmpc_mac_engine
package vmpc_pkg;

   // default store depths
   localparam int unsigned MAX_KEY_BYTES_DEF = 64;
   localparam int unsigned MAX_IV_BYTES_DEF  = 64;

   // counter width: holds 768 rounds and any store length
   localparam int unsigned LEN_W       = 10;
   localparam int unsigned KS_ROUNDS   = 768;
   localparam int unsigned POST_ROUNDS = 24;
   localparam int unsigned TAG_BYTES   = 20;
   localparam int unsigned PERM_SIZE   = 256;
   localparam int unsigned MIX_ROWS    = 8;

   // operation codes
   localparam logic [2:0] OP_LOAD_KEY = 3'd0;
   localparam logic [2:0] OP_LOAD_IV  = 3'd1;
   localparam logic [2:0] OP_INIT     = 3'd2;
   localparam logic [2:0] OP_MESSAGE  = 3'd3;
   localparam logic [2:0] OP_FINALIZE = 3'd4;

   // configuration register indexes
   localparam logic CSR_KEY_LENGTH = 1'b0;
   localparam logic CSR_IV_LENGTH  = 1'b1;

   typedef struct packed {
      logic [2:0] op;
      logic [5:0] load_index;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] tag_byte;
      logic [4:0] byte_index;
      logic       last;
      logic       not_ready;
   } rsp_type;

   typedef enum logic [5:0] {
      DP_NOP, DP_FILL, DP_LOAD, DP_CLEAR, DP_ERR,
      DP_KS0, DP_KS1, DP_KS2, DP_KS3, DP_KS4,
      DP_R0, DP_R1, DP_R2, DP_R3, DP_R4, DP_R5,
      DP_Y0, DP_Y1, DP_Y2, DP_Y3, DP_Y4, DP_Y5, DP_Y6, DP_Y7,
      DP_O0, DP_O1, DP_O2, DP_O3, DP_O4, DP_O5, DP_O6, DP_O7
   } dp_step_type;

   typedef enum logic [5:0] {
      ST_FILL, ST_IDLE, ST_DISPATCH, ST_LOAD, ST_ERR, ST_CLEAR,
      ST_KS0, ST_KS1, ST_KS2, ST_KS3, ST_KS4,
      ST_R0, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5,
      ST_Y0, ST_Y1, ST_Y2, ST_Y3, ST_Y4, ST_Y5, ST_Y6, ST_Y7,
      ST_O0, ST_O1, ST_O2, ST_O3, ST_O4, ST_O5, ST_O6, ST_O7
   } ctrl_state_type;

   typedef enum logic [1:0] {
      SRC_KEY, SRC_IV, SRC_MIX
   } src_type;

   typedef struct packed {
      dp_step_type step;
      src_type     src;
      logic        post;
      logic        cnt_clr;
      logic        cnt_inc;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       fill_end;
      logic       ks_end;
      logic       post_end;
      logic       out_end;
   } status_type;

endpackage

[rtl/vmpc_ctrl.sv]
// vmpc_ctrl: sequencer of the vmpc mac engine, issues one datapath step a cycle
// depends on vmpc_pkg
module vmpc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  vmpc_pkg::status_type status,
   output vmpc_pkg::cmd_type    cmd,
   output logic                 busy
);
   import vmpc_pkg::*;

   ctrl_state_type state_ff, state_in;
   src_type        phase_ff, phase_in;
   logic           post_ff, post_in;
   logic           init_ff, init_in;
   logic           ready_ff, ready_in;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         phase_ff <= SRC_KEY;
         post_ff  <= 1'b0;
         init_ff  <= 1'b0;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         post_ff  <= post_in;
         init_ff  <= init_in;
         ready_ff <= ready_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      post_in  = post_ff;
      init_in  = init_ff;
      ready_in = ready_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (status.op)
               OP_LOAD_KEY, OP_LOAD_IV: state_in = ST_LOAD;
               OP_INIT: begin
                  state_in = ST_CLEAR;
                  init_in  = 1'b1;
               end
               OP_MESSAGE: begin
                  state_in = ST_R0;
                  post_in  = 1'b0;
               end
               OP_FINALIZE: begin
                  if (ready_ff) begin
                     state_in = ST_R0;
                     post_in  = 1'b1;
                  end else begin
                     state_in = ST_ERR;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_LOAD:  state_in = ST_IDLE;
         ST_ERR:   state_in = ST_IDLE;
         ST_CLEAR: state_in = ST_FILL;
         ST_FILL: begin
            if (status.fill_end) begin
               if (init_ff) begin
                  state_in = ST_KS0;
                  phase_in = SRC_KEY;
                  init_in  = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_KS0: state_in = ST_KS1;
         ST_KS1: state_in = ST_KS2;
         ST_KS2: state_in = ST_KS3;
         ST_KS3: state_in = ST_KS4;
         ST_KS4: begin
            if (status.ks_end) begin
               case (phase_ff)
                  SRC_KEY: begin
                     phase_in = SRC_IV;
                     state_in = ST_KS0;
                  end
                  SRC_IV: begin
                     state_in = ST_IDLE;
                     ready_in = 1'b1;
                  end
                  default: state_in = ST_O0;
               endcase
            end else begin
               state_in = ST_KS0;
            end
         end
         ST_R0: state_in = ST_R1;
         ST_R1: state_in = ST_R2;
         ST_R2: state_in = post_ff ? ST_Y0 : ST_R3;
         ST_R3: state_in = ST_R4;
         ST_R4: state_in = ST_R5;
         ST_R5: state_in = ST_Y0;
         ST_Y0: state_in = ST_Y1;
         ST_Y1: state_in = ST_Y2;
         ST_Y2: state_in = ST_Y3;
         ST_Y3: state_in = ST_Y4;
         ST_Y4: state_in = ST_Y5;
         ST_Y5: state_in = ST_Y6;
         ST_Y6: state_in = ST_Y7;
         ST_Y7: begin
            if (!post_ff) begin
               state_in = ST_IDLE;
            end else if (status.post_end) begin
               phase_in = SRC_MIX;
               state_in = ST_KS0;
            end else begin
               state_in = ST_R0;
            end
         end
         ST_O0: state_in = ST_O1;
         ST_O1: state_in = ST_O2;
         ST_O2: state_in = ST_O3;
         ST_O3: state_in = ST_O4;
         ST_O4: state_in = ST_O5;
         ST_O5: state_in = ST_O6;
         ST_O6: state_in = ST_O7;
         ST_O7: begin
            if (status.out_end) begin
               state_in = ST_CLEAR;
               init_in  = 1'b1;
            end else begin
               state_in = ST_O0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd.step    = DP_NOP;
      cmd.src     = phase_ff;
      cmd.post    = post_ff;
      cmd.cnt_clr = 1'b0;
      cmd.cnt_inc = 1'b0;
      case (state_ff)
         ST_DISPATCH: cmd.cnt_clr = 1'b1;
         ST_LOAD:     cmd.step = DP_LOAD;
         ST_ERR:      cmd.step = DP_ERR;
         ST_CLEAR:    cmd.step = DP_CLEAR;
         ST_FILL: begin
            cmd.step    = DP_FILL;
            cmd.cnt_inc = 1'b1;
            cmd.cnt_clr = status.fill_end;
         end
         ST_KS0: cmd.step = DP_KS0;
         ST_KS1: cmd.step = DP_KS1;
         ST_KS2: cmd.step = DP_KS2;
         ST_KS3: cmd.step = DP_KS3;
         ST_KS4: begin
            cmd.step    = DP_KS4;
            cmd.cnt_inc = 1'b1;
            cmd.cnt_clr = status.ks_end;
         end
         ST_R0: cmd.step = DP_R0;
         ST_R1: cmd.step = DP_R1;
         ST_R2: cmd.step = DP_R2;
         ST_R3: cmd.step = DP_R3;
         ST_R4: cmd.step = DP_R4;
         ST_R5: cmd.step = DP_R5;
         ST_Y0: cmd.step = DP_Y0;
         ST_Y1: cmd.step = DP_Y1;
         ST_Y2: cmd.step = DP_Y2;
         ST_Y3: cmd.step = DP_Y3;
         ST_Y4: cmd.step = DP_Y4;
         ST_Y5: cmd.step = DP_Y5;
         ST_Y6: cmd.step = DP_Y6;
         ST_Y7: begin
            cmd.step    = DP_Y7;
            cmd.cnt_inc = post_ff;
            cmd.cnt_clr = post_ff && status.post_end;
         end
         ST_O0: cmd.step = DP_O0;
         ST_O1: cmd.step = DP_O1;
         ST_O2: cmd.step = DP_O2;
         ST_O3: cmd.step = DP_O3;
         ST_O4: cmd.step = DP_O4;
         ST_O5: cmd.step = DP_O5;
         ST_O6: cmd.step = DP_O6;
         ST_O7: begin
            cmd.step    = DP_O7;
            cmd.cnt_inc = 1'b1;
         end
         default: cmd.step = DP_NOP;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[rtl/vmpc_datapath.sv]
// vmpc_datapath: permutation memory, key and iv stores, mix table and mac registers
// depends on vmpc_pkg; driven step by step by vmpc_ctrl
module vmpc_datapath #(
   parameter int unsigned MAX_KEY_BYTES = vmpc_pkg::MAX_KEY_BYTES_DEF,
   parameter int unsigned MAX_IV_BYTES  = vmpc_pkg::MAX_IV_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  vmpc_pkg::req_type    req_item,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [6:0]           csr_wdata,
   input  vmpc_pkg::cmd_type    cmd,
   output vmpc_pkg::status_type status,
   output logic                 rsp_strobe,
   output vmpc_pkg::rsp_type    rsp_item
);
   import vmpc_pkg::*;

   localparam int unsigned KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int unsigned IAW = (MAX_IV_BYTES > 1) ? $clog2(MAX_IV_BYTES) : 1;

   // memories
   logic [7:0]  perm_mem [PERM_SIZE];
   logic [7:0]  key_mem  [MAX_KEY_BYTES];
   logic [7:0]  iv_mem   [MAX_IV_BYTES];

   // registers
   req_type     req_ff;
   logic [7:0]  pd_ff, kd_ff, ivd_ff;
   logic [7:0]  s_ff, s_in, n_ff, n_in;
   logic [2:0]  g_ff, g_in;
   logic [7:0]  x_ff [4];
   logic [7:0]  x_in [4];
   logic [7:0]  ta_ff, ta_in, d1_ff, d1_in, d2_ff, d2_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in, k_ff, k_in;
   logic [31:0] mix_ff [MIX_ROWS];
   logic [31:0] mix_row_in;
   logic        mix_we, mix_clr;
   logic [6:0]  key_len_ff, iv_len_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_strobe_ff, rsp_strobe_in;

   // combinational signals
   logic [7:0]  rd_addr, wr_addr, wr_data;
   logic        wr_en;
   logic        key_we, iv_we;
   logic [LEN_W-1:0] load_idx, key_eff, iv_eff, len_eff;
   logic [2:0]  mix_sel;
   logic [31:0] mix_row;
   logic [7:0]  mix_byte, src_byte;

   // effective store lengths: zero counts as one, clipped at the depth
   always_comb begin
      key_eff = {{(LEN_W-7){1'b0}}, key_len_ff};
      if (key_len_ff == 7'd0) key_eff = LEN_W'(1);
      else if (key_eff > LEN_W'(MAX_KEY_BYTES)) key_eff = LEN_W'(MAX_KEY_BYTES);
      iv_eff = {{(LEN_W-7){1'b0}}, iv_len_ff};
      if (iv_len_ff == 7'd0) iv_eff = LEN_W'(1);
      else if (iv_eff > LEN_W'(MAX_IV_BYTES)) iv_eff = LEN_W'(MAX_IV_BYTES);
   end

   assign len_eff  = (cmd.src == SRC_IV) ? iv_eff : key_eff;
   assign load_idx = {{(LEN_W-6){1'b0}}, req_ff.load_index};

   // mix table row select: round update row or key schedule source row
   assign mix_sel  = (cmd.step == DP_Y4) ? g_ff : cnt_ff[4:2];
   assign mix_row  = mix_ff[mix_sel];
   assign mix_byte = mix_row[8*cnt_ff[1:0] +: 8];

   always_comb begin
      case (cmd.src)
         SRC_KEY: src_byte = kd_ff;
         SRC_IV:  src_byte = ivd_ff;
         default: src_byte = mix_byte;
      endcase
   end

   // store writes
   assign key_we = (cmd.step == DP_LOAD) && (req_ff.op == OP_LOAD_KEY)
                   && (load_idx < LEN_W'(MAX_KEY_BYTES));
   assign iv_we  = (cmd.step == DP_LOAD) && (req_ff.op == OP_LOAD_IV)
                   && (load_idx < LEN_W'(MAX_IV_BYTES));

   // step decode
   always_comb begin
      rd_addr       = 8'd0;
      wr_en         = 1'b0;
      wr_addr       = 8'd0;
      wr_data       = 8'd0;
      s_in          = s_ff;
      n_in          = n_ff;
      g_in          = g_ff;
      x_in          = x_ff;
      ta_in         = ta_ff;
      d1_in         = d1_ff;
      d2_in         = d2_ff;
      mix_we        = 1'b0;
      mix_clr       = 1'b0;
      mix_row_in    = mix_row;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      case (cmd.step)
         DP_FILL: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[7:0];
            wr_data = cnt_ff[7:0];
         end
         DP_CLEAR: begin
            s_in    = 8'd0;
            n_in    = 8'd0;
            g_in    = 3'd0;
            x_in    = '{default: 8'd0};
            mix_clr = 1'b1;
         end
         DP_ERR: begin
            rsp_in        = '{tag_byte: 8'd0, byte_index: 5'd0, last: 1'b1,
                              not_ready: 1'b1};
            rsp_strobe_in = 1'b1;
         end
         // key schedule round
         DP_KS0: rd_addr = cnt_ff[7:0];
         DP_KS1: begin
            ta_in   = pd_ff;
            rd_addr = s_ff + pd_ff + src_byte;
         end
         DP_KS2: begin
            s_in    = pd_ff;
            rd_addr = pd_ff;
         end
         DP_KS3: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[7:0];
            wr_data = pd_ff;
         end
         DP_KS4: begin
            wr_en   = 1'b1;
            wr_addr = s_ff;
            wr_data = ta_ff;
         end
         // s update and keystream byte
         DP_R0: begin
            rd_addr = n_ff;
            d1_in   = cmd.post ? (cnt_ff[7:0] + 8'd1) : 8'd0;
            if (cmd.post) d2_in = cnt_ff[7:0] + 8'd1;
         end
         DP_R1: rd_addr = s_ff + pd_ff;
         DP_R2: begin
            s_in    = pd_ff;
            rd_addr = pd_ff;
         end
         DP_R3: rd_addr = pd_ff;
         DP_R4: rd_addr = pd_ff + 8'd1;
         DP_R5: d2_in = req_ff.data_byte ^ pd_ff;
         // mac round: x registers, mix row, swap
         DP_Y0: rd_addr = x_ff[3] + x_ff[2] + d1_ff;
         DP_Y1: begin
            x_in[3] = pd_ff;
            rd_addr = x_ff[2] + x_ff[1] + d1_ff;
         end
         DP_Y2: begin
            x_in[2] = pd_ff;
            rd_addr = x_ff[1] + x_ff[0] + d1_ff;
         end
         DP_Y3: begin
            x_in[1] = pd_ff;
            rd_addr = x_ff[0] + s_ff + d2_ff;
         end
         DP_Y4: begin
            x_in[0]    = pd_ff;
            mix_we     = 1'b1;
            mix_row_in = mix_row ^ {x_ff[3], x_ff[2], x_ff[1], pd_ff};
            g_in       = g_ff + 3'd1;
            rd_addr    = n_ff;
         end
         DP_Y5: begin
            ta_in   = pd_ff;
            rd_addr = s_ff;
         end
         DP_Y6: begin
            wr_en   = 1'b1;
            wr_addr = n_ff;
            wr_data = pd_ff;
         end
         DP_Y7: begin
            wr_en   = 1'b1;
            wr_addr = s_ff;
            wr_data = ta_ff;
            n_in    = n_ff + 8'd1;
         end
         // tag output round
         DP_O0: rd_addr = cnt_ff[7:0];
         DP_O1: begin
            ta_in   = pd_ff;
            rd_addr = s_ff + pd_ff;
         end
         DP_O2: begin
            s_in    = pd_ff;
            rd_addr = pd_ff;
         end
         DP_O3: rd_addr = pd_ff;
         DP_O4: rd_addr = pd_ff + 8'd1;
         DP_O5: begin
            rsp_in        = '{tag_byte: pd_ff, byte_index: cnt_ff[4:0],
                              last: (cnt_ff == LEN_W'(TAG_BYTES - 1)), not_ready: 1'b0};
            rsp_strobe_in = 1'b1;
            rd_addr       = s_ff;
         end
         DP_O6: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[7:0];
            wr_data = pd_ff;
         end
         DP_O7: begin
            wr_en   = 1'b1;
            wr_addr = s_ff;
            wr_data = ta_ff;
         end
         default: rd_addr = 8'd0;
      endcase
   end

   // round counter and cyclic store pointer
   always_comb begin
      cnt_in = cnt_ff;
      k_in   = k_ff;
      if (cmd.cnt_clr || (cmd.step == DP_CLEAR)) begin
         cnt_in = '0;
         k_in   = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + LEN_W'(1);
         if (cmd.step == DP_KS4) k_in = ((k_ff + LEN_W'(1)) == len_eff) ? '0 : k_ff + LEN_W'(1);
      end
   end

   // status to the sequencer
   assign status.op       = req_ff.op;
   assign status.fill_end = (cnt_ff == LEN_W'(PERM_SIZE - 1));
   assign status.ks_end   = (cnt_ff == LEN_W'(KS_ROUNDS - 1));
   assign status.post_end = (cnt_ff == LEN_W'(POST_ROUNDS - 1));
   assign status.out_end  = (cnt_ff == LEN_W'(TAG_BYTES - 1));

   // permutation memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) perm_mem[wr_addr] <= wr_data;
      pd_ff <= perm_mem[rd_addr];
   end

   // key and iv stores, registered read at the cyclic pointer
   always_ff @(posedge clock) begin
      if (key_we) key_mem[load_idx[KAW-1:0]] <= req_ff.data_byte;
      kd_ff <= key_mem[k_ff[KAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (iv_we) iv_mem[load_idx[IAW-1:0]] <= req_ff.data_byte;
      ivd_ff <= iv_mem[k_ff[IAW-1:0]];
   end

   // transaction capture and working registers without reset
   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_item;
      ta_ff  <= ta_in;
      d1_ff  <= d1_in;
      d2_ff  <= d2_in;
      rsp_ff <= rsp_in;
   end

   // mac state, counters and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff          <= 8'd0;
         n_ff          <= 8'd0;
         g_ff          <= 3'd0;
         x_ff          <= '{default: 8'd0};
         mix_ff        <= '{default: 32'd0};
         cnt_ff        <= '0;
         k_ff          <= '0;
         key_len_ff    <= 7'd16;
         iv_len_ff     <= 7'd16;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s_ff          <= s_in;
         n_ff          <= n_in;
         g_ff          <= g_in;
         x_ff          <= x_in;
         cnt_ff        <= cnt_in;
         k_ff          <= k_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (mix_clr) mix_ff <= '{default: 32'd0};
         else if (mix_we) mix_ff[mix_sel] <= mix_row_in;
         if (csr_we && (csr_index == CSR_KEY_LENGTH)) key_len_ff <= csr_wdata;
         if (csr_we && (csr_index == CSR_IV_LENGTH)) iv_len_ff <= csr_wdata;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

[rtl/vmpc_mac_engine.sv]
// vmpc_mac_engine: top level of the vmpc mac engine
// depends on vmpc_pkg, vmpc_ctrl and vmpc_datapath
//
//   channel   ports                                   direction
//   request   start, req_item (in), busy (out)        in
//   response  rsp_strobe, rsp_item                     out
//   config    csr_we, csr_index, csr_wdata             in
//
// init fills the permutation, then runs 768 key schedule rounds over the key and 768
// over the iv; finalize runs 24 post rounds, 768 key schedule rounds over the mix table
// and 20 tag rounds that each emit one tag byte, then a re-init
// the permutation memory has a single read port, whose read data is registered,
// so every dependent lookup waits for the previous read
// after reset the permutation is filled with identity, busy high
// results carry a one-cycle strobe; the receiver cannot stall them
module vmpc_mac_engine #(
   parameter int unsigned MAX_KEY_BYTES = vmpc_pkg::MAX_KEY_BYTES_DEF,
   parameter int unsigned MAX_IV_BYTES  = vmpc_pkg::MAX_IV_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vmpc_pkg::req_type req_item,
   output logic              rsp_strobe,
   output vmpc_pkg::rsp_type rsp_item,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [6:0]        csr_wdata
);
   import vmpc_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       accept;

   // transaction accepted when idle
   assign accept = start && !busy;

   vmpc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   vmpc_datapath #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES),
      .MAX_IV_BYTES  (MAX_IV_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_item   (req_item),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
